### rtl/hslc_pkg.sv
package hslc_pkg;

    // fixed point format of every intermediate value
    localparam int FRAC_BITS = 12;
    localparam int VAL_W     = FRAC_BITS + 1;        // holds 0 .. ONE
    localparam int SUM_W     = FRAC_BITS + 2;        // holds 0 .. 2*ONE
    localparam int PROD_W    = 2 * VAL_W;
    localparam int BYTE_W    = 8;

    localparam logic [VAL_W-1:0]     ONE        = VAL_W'(1 << FRAC_BITS);
    localparam logic [FRAC_BITS-1:0] HALF       = FRAC_BITS'((1 << FRAC_BITS) / 2);
    localparam logic [FRAC_BITS-1:0] THIRD      = FRAC_BITS'(((1 << FRAC_BITS) + 1) / 3);
    localparam logic [FRAC_BITS-1:0] TWO_THIRDS =
        FRAC_BITS'((1 << FRAC_BITS) - ((1 << FRAC_BITS) + 1) / 3);

    // hue segment limits: 6h < ONE and 3h < 2*ONE as plain compares
    localparam logic [FRAC_BITS-1:0] RISE_LIM =
        FRAC_BITS'(((1 << FRAC_BITS) + 5) / 6);
    localparam logic [FRAC_BITS-1:0] FALL_LIM =
        FRAC_BITS'((2 * (1 << FRAC_BITS) + 2) / 3);

    // length of the valid shift register that carries an accepted beat to its done strobe
    localparam int LATENCY = 6;

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_FLAT,
        SEG_FALL,
        SEG_LOW
    } hue_seg_t;

    // lightness levels shared by the three color channels
    typedef struct packed {
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic [VAL_W-1:0] diff;
    } levels_t;

    // floor(v * 255 / ONE), saturated to one byte
    function automatic logic [BYTE_W-1:0] to_byte(input logic [SUM_W-1:0] v);
        logic [SUM_W+BYTE_W-1:0] scaled;
        logic [SUM_W-FRAC_BITS+BYTE_W-1:0] whole;
        scaled = {v, BYTE_W'(0)} - (SUM_W + BYTE_W)'(v);
        whole  = scaled[SUM_W+BYTE_W-1:FRAC_BITS];
        if (whole > (SUM_W - FRAC_BITS + BYTE_W)'(255))
            return BYTE_W'(255);
        else
            return whole[BYTE_W-1:0];
    endfunction

endpackage

### rtl/hslc_channel.sv
module hslc_channel
    import hslc_pkg::*;
(
    input  logic                 clk,
    input  logic [FRAC_BITS-1:0] hue,      // stage 1 hue of this channel
    input  levels_t              levels,   // stage 3 levels
    output logic [BYTE_W-1:0]    level     // stage 6 byte
);

    hue_seg_t          seg_next;
    logic [VAL_W-1:0]  factor_next;
    logic [FRAC_BITS-1:0] fall_dist;

    hue_seg_t          seg2_reg, seg3_reg, seg4_reg;
    logic [VAL_W-1:0]  factor2_reg, factor3_reg;
    logic [PROD_W-1:0] prod4_reg;
    logic [VAL_W-1:0]  lo4_reg, hi4_reg;
    logic [SUM_W-1:0]  value5_reg, value_next;
    logic [BYTE_W-1:0] level_reg;

    // segment of the hue and slope factor (6h or 6*(2/3 - h))
    always_comb
    begin
        fall_dist   = TWO_THIRDS - hue;
        seg_next    = SEG_LOW;
        factor_next = '0;
        if (hue < RISE_LIM)
        begin
            seg_next    = SEG_RISE;
            factor_next = (VAL_W'(hue) << 2) + (VAL_W'(hue) << 1);
        end
        else if (hue < HALF)
        begin
            seg_next = SEG_FLAT;
        end
        else if (hue < FALL_LIM)
        begin
            seg_next    = SEG_FALL;
            factor_next = (VAL_W'(fall_dist) << 2) + (VAL_W'(fall_dist) << 1);
        end
    end

    // pick the channel value from its segment
    always_comb
    begin
        case (seg4_reg)
            SEG_RISE, SEG_FALL: value_next = SUM_W'(lo4_reg)
                                           + SUM_W'(prod4_reg[PROD_W-1:FRAC_BITS]);
            SEG_FLAT:           value_next = SUM_W'(hi4_reg);
            default:            value_next = SUM_W'(lo4_reg);
        endcase
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        seg2_reg    <= seg_next;
        factor2_reg <= factor_next;
        seg3_reg    <= seg2_reg;
        factor3_reg <= factor2_reg;
        prod4_reg   <= PROD_W'(levels.diff) * PROD_W'(factor3_reg);
        lo4_reg     <= levels.lo;
        hi4_reg     <= levels.hi;
        seg4_reg    <= seg3_reg;
        value5_reg  <= value_next;
        level_reg   <= to_byte(value5_reg);
    end

    assign level = level_reg;

endmodule

### rtl/hsl_to_rgba_convert_unit.sv
// hsl to rgba color conversion, six register stages
// an accepted beat passes down the valid shift register and raises done together with its color bytes
// throughput: one beat per cycle, busy is always low; results cannot be stalled
// stage 2 holds the l*s multiply, stage 4 the three slope multiplies
// reset (rst_n, async, active low) clears the valid pipeline only
module hsl_to_rgba_convert_unit
    import hslc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [11:0]          hue,
    input  logic [12:0]          saturation,
    input  logic [12:0]          lightness,
    input  logic [12:0]          alpha,
    output logic                 done,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue,
    output logic [7:0]           opacity
);

    logic                  accept;
    logic [LATENCY-1:0]    valid_reg, valid_next;

    logic [FRAC_BITS-1:0]  hue_g1_reg, hue_r1_reg, hue_b1_reg;
    logic [VAL_W-1:0]      sat1_reg, lig1_reg, alp1_reg;
    logic [PROD_W-1:0]     prod2_reg;
    logic [VAL_W-1:0]      sat2_reg, lig2_reg;
    logic [BYTE_W-1:0]     op2_reg, op3_reg, op4_reg, op5_reg, opacity_reg;
    levels_t               levels3_reg, levels_next;

    logic [SUM_W-1:0]      hi_wide, lig_dbl, lo_wide;
    logic [VAL_W-1:0]      hi_sat, lo_sat;
    logic [VAL_W-1:0]      prod_hi;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits travel with the beat
    always_comb
    begin
        valid_next = {valid_reg[LATENCY-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // high and low lightness levels
    always_comb
    begin
        prod_hi = prod2_reg[FRAC_BITS+VAL_W-1:FRAC_BITS];
        if (lig2_reg < VAL_W'(HALF))
            hi_wide = SUM_W'(lig2_reg) + SUM_W'(prod_hi);
        else
            hi_wide = SUM_W'(lig2_reg) + SUM_W'(sat2_reg) - SUM_W'(prod_hi);
        hi_sat  = (hi_wide > SUM_W'(ONE)) ? ONE : hi_wide[VAL_W-1:0];
        lig_dbl = SUM_W'(lig2_reg) << 1;
        lo_wide = (lig_dbl >= SUM_W'(hi_sat)) ? lig_dbl - SUM_W'(hi_sat) : '0;
        lo_sat  = (lo_wide > SUM_W'(hi_sat)) ? hi_sat : lo_wide[VAL_W-1:0];
        levels_next.hi   = hi_sat;
        levels_next.lo   = lo_sat;
        levels_next.diff = hi_sat - lo_sat;
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        // stage 1: clamp inputs and offset the channel hues
        hue_g1_reg  <= hue;
        hue_r1_reg  <= hue + THIRD;
        hue_b1_reg  <= hue + TWO_THIRDS;
        sat1_reg    <= (saturation > ONE) ? ONE : saturation;
        lig1_reg    <= (lightness > ONE) ? ONE : lightness;
        alp1_reg    <= (alpha > ONE) ? ONE : alpha;
        // stage 2: l*s product and opacity byte
        prod2_reg   <= PROD_W'(lig1_reg) * PROD_W'(sat1_reg);
        sat2_reg    <= sat1_reg;
        lig2_reg    <= lig1_reg;
        op2_reg     <= to_byte(SUM_W'(alp1_reg));
        // stage 3: levels
        levels3_reg <= levels_next;
        op3_reg     <= op2_reg;
        // stages 4 to 6: opacity waits for the color channels
        op4_reg     <= op3_reg;
        op5_reg     <= op4_reg;
        opacity_reg <= op5_reg;
    end

    hslc_channel u_red
    (
        .clk    (clk),
        .hue    (hue_r1_reg),
        .levels (levels3_reg),
        .level  (red)
    );

    hslc_channel u_green
    (
        .clk    (clk),
        .hue    (hue_g1_reg),
        .levels (levels3_reg),
        .level  (green)
    );

    hslc_channel u_blue
    (
        .clk    (clk),
        .hue    (hue_b1_reg),
        .levels (levels3_reg),
        .level  (blue)
    );

    assign done    = valid_reg[LATENCY-1];
    assign opacity = opacity_reg;

`ifndef NO_ASSERTIONS
    // every accepted beat comes out after a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted beat did not complete on time");

    // no strobe without a beat accepted at the right time
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("done without an accepted beat");

    // full or overrange alpha gives full opacity
    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(alpha, LATENCY) >= ONE)) |-> (opacity == 8'd255))
        else $error("opaque alpha did not give full opacity");
`endif

endmodule

### test/hsl_to_rgba_convert_unit_test.sv
module hsl_to_rgba_convert_unit_test;

    // fixed point format used by the color predictor
    localparam int unsigned FRAC        = 12;
    localparam int unsigned LVL_ONE     = 1 << FRAC;
    localparam int unsigned LVL_HALF    = LVL_ONE / 2;
    localparam int unsigned HUE_THIRD   = (LVL_ONE + 1) / 3;
    localparam int unsigned HUE_TWO_3RD = LVL_ONE - HUE_THIRD;

    // run length
    localparam int unsigned RANDOM_COLORS = 1500;
    localparam int unsigned DRAIN_CYCLES  = 12;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PRINT_CAP     = 60;
    localparam int unsigned N_CORNERS     = 22;

    typedef struct packed {
        logic [11:0] hue;
        logic [12:0] saturation;
        logic [12:0] lightness;
        logic [12:0] alpha;
    } hsl_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } rgba_t;

    // predicts each color and compares it with what the block returns
    class rgba_scoreboard;
        rgba_t       pending_rgba[$];
        int unsigned mismatches;
        int unsigned colors_in;
        int unsigned colors_out;
        int unsigned clipped_levels;

        function int unsigned pending();
            return pending_rgba.size();
        endfunction

        // levels above full scale count as full scale
        function logic [12:0] clip_level(logic [12:0] v);
            return (v > LVL_ONE) ? 13'(LVL_ONE) : v;
        endfunction

        function logic [7:0] level_to_byte(logic [13:0] v);
            logic [31:0] b;
            b = (32'(v) * 32'd255) >> FRAC;
            return (b > 32'd255) ? 8'd255 : b[7:0];
        endfunction

        // piecewise linear level of one channel along the hue circle
        function logic [13:0] hue_level(logic [13:0] lo, logic [13:0] hi, logic [11:0] h);
            logic [31:0] d;
            logic [31:0] hh;
            d  = 32'(hi) - 32'(lo);
            hh = 32'(h);
            if (hh * 6 < LVL_ONE)
                return 14'(32'(lo) + ((d * hh * 6) >> FRAC));
            else if (hh * 2 < LVL_ONE)
                return hi;
            else if (hh * 3 < 2 * LVL_ONE)
                return 14'(32'(lo) + ((d * (HUE_TWO_3RD - hh) * 6) >> FRAC));
            else
                return lo;
        endfunction

        function rgba_t hsl_to_rgba(hsl_t c);
            logic [12:0] s;
            logic [12:0] l;
            logic [12:0] a;
            logic [31:0] prod;
            logic [31:0] twice_l;
            logic [13:0] hi;
            logic [13:0] lo;
            logic [11:0] hue_r;
            logic [11:0] hue_b;
            rgba_t       r;
            s = clip_level(c.saturation);
            l = clip_level(c.lightness);
            a = clip_level(c.alpha);
            // upper and lower levels shared by the three channels
            if (l < LVL_HALF)
            begin
                prod = 32'(l) * (LVL_ONE + 32'(s));
                hi   = 14'(prod >> FRAC);
            end
            else
            begin
                prod = 32'(l) * 32'(s);
                hi   = 14'(32'(l) + 32'(s) - (prod >> FRAC));
            end
            if (hi > LVL_ONE)
                hi = 14'(LVL_ONE);
            twice_l = 2 * 32'(l);
            lo = (twice_l >= 32'(hi)) ? 14'(twice_l - 32'(hi)) : 14'd0;
            if (lo > hi)
                lo = hi;
            // channel hues wrap around the turn
            hue_r = c.hue + 12'(HUE_THIRD);
            hue_b = c.hue + 12'(HUE_TWO_3RD);
            r.red     = level_to_byte(hue_level(lo, hi, hue_r));
            r.green   = level_to_byte(hue_level(lo, hi, c.hue));
            r.blue    = level_to_byte(hue_level(lo, hi, hue_b));
            r.opacity = level_to_byte(14'(a));
            return r;
        endfunction

        function void note_color(hsl_t c);
            pending_rgba.push_back(hsl_to_rgba(c));
            colors_in++;
            if (c.saturation > LVL_ONE || c.lightness > LVL_ONE || c.alpha > LVL_ONE)
                clipped_levels++;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("error: %s", msg);
        endtask

        task check_color(rgba_t got);
            rgba_t want;
            colors_out++;
            if (pending_rgba.size() == 0)
            begin
                report($sformatf("unexpected color %h", got));
            end
            else
            begin
                want = pending_rgba.pop_front();
                if (got.red !== want.red)
                    report($sformatf("color %0d red %0d, want %0d",
                                     colors_out, got.red, want.red));
                if (got.green !== want.green)
                    report($sformatf("color %0d green %0d, want %0d",
                                     colors_out, got.green, want.green));
                if (got.blue !== want.blue)
                    report($sformatf("color %0d blue %0d, want %0d",
                                     colors_out, got.blue, want.blue));
                if (got.opacity !== want.opacity)
                    report($sformatf("color %0d opacity %0d, want %0d",
                                     colors_out, got.opacity, want.opacity));
            end
        endtask
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [11:0] hue        = '0;
    logic [12:0] saturation = '0;
    logic [12:0] lightness  = '0;
    logic [12:0] alpha      = '0;
    logic        busy;
    logic        done;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  opacity;

    int unsigned    cycle_count = 0;
    rgba_scoreboard board       = new();

    // primaries, segment edges, clipped levels and alternating bit patterns
    hsl_t corner_colors [N_CORNERS] = '{
        '{12'd0,     13'd0,      13'd0,      13'd0},
        '{12'd0,     13'd4096,   13'd2048,   13'd4096},
        '{12'd1365,  13'd4096,   13'd2048,   13'd4096},
        '{12'd2731,  13'd4096,   13'd2048,   13'd4096},
        '{12'd4095,  13'd4096,   13'd2048,   13'd4095},
        '{12'd0,     13'd0,      13'd4096,   13'd4096},
        '{12'd0,     13'd8191,   13'd8191,   13'd8191},
        '{12'd682,   13'd4096,   13'd2047,   13'd4097},
        '{12'd683,   13'd4096,   13'd2048,   13'd2048},
        '{12'd2047,  13'd2048,   13'd1024,   13'd1},
        '{12'd2048,  13'd2048,   13'd3072,   13'd4095},
        '{12'd2730,  13'd4096,   13'd1000,   13'd100},
        '{12'd2731,  13'd4096,   13'd3000,   13'd3000},
        '{12'd1366,  13'd3000,   13'd2047,   13'd0},
        '{12'd3413,  13'd3000,   13'd2049,   13'd4096},
        '{12'd3414,  13'd1,      13'd1,      13'd8191},
        '{12'd4095,  13'd8191,   13'd0,      13'd5000},
        '{12'd1234,  13'd4097,   13'd4097,   13'd6000},
        '{12'd2000,  13'd4095,   13'd4095,   13'd4095},
        '{12'd3000,  13'd1,      13'd4095,   13'd2},
        '{12'hAAA,   13'h1555,   13'h0AAA,   13'h1555},
        '{12'h555,   13'h0AAA,   13'h1555,   13'h0AAA}
    };

    hsl_to_rgba_convert_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .alpha      (alpha),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .opacity    (opacity)
    );

    always #5 clk = ~clk;

    // each strobed color is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_color(rgba_t'{red, green, blue, opacity});
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("hsl_to_rgba_convert_unit: mismatch");
        $finish;
    end

    // mostly in range, with corners and over-range values mixed in
    function automatic logic [12:0] pick_level();
        int unsigned r;
        int unsigned corner;
        r = $urandom_range(0, 9);
        corner = $urandom_range(0, 5);
        if (r == 0)
            return (corner < 2) ? 13'(corner) : 13'(2046 + corner) + ((corner > 3) ? 13'd2045 : 13'd0);
        else if (r == 1)
            return 13'($urandom_range(LVL_ONE + 1, 8191));
        else
            return 13'($urandom_range(0, LVL_ONE));
    endfunction

    // uniform hue, sometimes on or next to a segment edge of some channel
    function automatic logic [11:0] pick_hue();
        int unsigned edges [6] = '{0, 683, 1365, 2048, 2731, 3413};
        if ($urandom_range(0, 7) == 0)
            return 12'(edges[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1);
        else
            return 12'($urandom_range(0, 4095));
    endfunction

    task automatic send_color(hsl_t c, int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        hue        <= c.hue;
        saturation <= c.saturation;
        lightness  <= c.lightness;
        alpha      <= c.alpha;
        do
            @(posedge clk);
        while (busy);
        board.note_color(c);
    endtask

    task automatic drain_colors();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        hsl_t        c;
        int unsigned gap;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, back to back then with gaps
        for (int i = 0; i < N_CORNERS; i++)
            send_color(corner_colors[i], (i < N_CORNERS / 2) ? 0 : $urandom_range(0, 3));
        drain_colors();

        // random colors, bursts alternating with idle gaps
        for (int i = 0; i < RANDOM_COLORS; i++)
        begin
            if (i == RANDOM_COLORS / 2)
                drain_colors();
            c.hue        = pick_hue();
            c.saturation = pick_level();
            c.lightness  = pick_level();
            c.alpha      = pick_level();
            gap = ((i / 150) % 2 == 1) ? 0 : $urandom_range(0, 3);
            send_color(c, gap);
        end
        drain_colors();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d colors, %0d of them with a level past full scale",
                 board.colors_in, board.colors_out > 0 ? board.clipped_levels : 0);
        $display("hue edges, primaries, clipped levels and back to back bursts exercised");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("hsl_to_rgba_convert_unit: match");
        else
            $display("hsl_to_rgba_convert_unit: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/hslc_pkg.sv
rtl/hslc_channel.sv
rtl/hsl_to_rgba_convert_unit.sv
test/hsl_to_rgba_convert_unit_test.sv
